FILE: hw/rtl/assert_macros.svh
// Assertion helpers, all clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mte_pkg.sv
`default_nettype none

package mte_pkg;

  // MAX_DELAY must be a power of two: the delay lines wrap by address overflow
  localparam int MAX_DELAY  = 4096;
  localparam int MAX_ECHOES = 8;

  localparam int ADDR_W     = $clog2(MAX_DELAY);
  localparam int SEEN_W     = $clog2(MAX_DELAY + 1);
  localparam int LEFT_W     = $clog2(MAX_ECHOES + 1);

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 13;
  localparam int ATT_W      = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int ATT_ONE    = 32768;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd2205;
  localparam logic [ATT_W-1:0]   ATT_RESET   = 16'd16384;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY = 2'd0,
    REG_ATT   = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  // What one cell hands to the next for one sample
  typedef struct packed {
    logic                       vld;
    logic                       rd_ok;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic [LEFT_W-1:0]          left;
    logic signed [SAMPLE_W-1:0] echo;
    logic signed [SAMPLE_W-1:0] sum;
  } tap_t;

  // att * v / 32768, truncated toward zero; att is at most 1.0
  function automatic logic signed [SAMPLE_W-1:0] attenuate(
    input logic signed [SAMPLE_W-1:0] v,
    input logic [ATT_W-1:0]           att
  );
    logic signed [SAMPLE_W+ATT_W:0] prod;
    logic signed [SAMPLE_W+ATT_W:0] bias;
    prod = v * $signed({1'b0, att});
    bias = prod[SAMPLE_W+ATT_W] ? (SAMPLE_W+ATT_W+1)'(32767) : '0;
    prod = prod + bias;
    return prod[SAMPLE_W+14:15];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/multi_tap_echo_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Feed-forward multi-tap echo: one signed 16-bit sample in, one out. A row of
// MAX_ECHOES cells, each with its own MAX_DELAY-deep delay line, passes every
// sample along one cell per cycle while the row advances; each cell writes its
// input into its line, reads the sample delay_samples back, scales it by
// attenuation_q15 and adds it to the running sum while echoes remain to be
// counted. The block takes one sample per cycle; a result passes through the
// cell registers and then the output register, and input stalls only when the
// output register is held and the last cell is occupied. clip_start clears the
// history count, so echoes start from silence; no clearing pass runs after
// reset. Change the registers only while no sample is in flight.
module multi_tap_echo_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [mte_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic                             clip_start,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [mte_pkg::SAMPLE_W-1:0]   sample_out,
  input  wire logic                             cfg_we,
  input  wire logic [mte_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mte_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mte_pkg::*;

  logic [DELAY_W-1:0] delay_samples;
  logic [ATT_W-1:0]   attenuation_q15;
  logic [COUNT_W-1:0] echo_count;

  logic [ADDR_W-1:0]  wpos;
  logic [SEEN_W-1:0]  seen;

  logic [SEEN_W-1:0]  delay_sat;
  logic [ATT_W-1:0]   att_sat;
  logic [LEFT_W-1:0]  count_sat;
  logic [SEEN_W-1:0]  seen_eff;
  logic [SEEN_W-1:0]  seen_next;
  logic               accept;
  logic               out_free;
  logic               adv;

  tap_t chain [MAX_ECHOES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples   <= DELAY_RESET;
      attenuation_q15 <= ATT_RESET;
      echo_count      <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY: delay_samples   <= cfg_data[DELAY_W-1:0];
        REG_ATT:   attenuation_q15 <= cfg_data[ATT_W-1:0];
        REG_COUNT: echo_count      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delay_samples == '0) begin
      delay_sat = SEEN_W'(1);
    end else if (int'(delay_samples) > MAX_DELAY) begin
      delay_sat = SEEN_W'(MAX_DELAY);
    end else begin
      delay_sat = SEEN_W'(delay_samples);
    end
    att_sat = (int'(attenuation_q15) > ATT_ONE) ? ATT_W'(ATT_ONE) : attenuation_q15;
    count_sat = (int'(echo_count) > MAX_ECHOES) ? LEFT_W'(MAX_ECHOES)
                                                : LEFT_W'(echo_count);
  end

  assign seen_eff  = clip_start ? '0 : seen;
  assign seen_next = (int'(seen_eff) < MAX_DELAY) ? seen_eff + SEEN_W'(1) : seen_eff;

  assign out_free = !out_valid || out_ready;
  assign adv      = out_free || !chain[MAX_ECHOES].vld;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
      seen <= '0;
    end else if (accept) begin
      wpos <= wpos + ADDR_W'(1);
      seen <= seen_next;
    end
  end

  always_comb begin
    chain[0].vld     = in_valid;
    chain[0].rd_ok   = seen_eff >= delay_sat;
    chain[0].rd_addr = wpos - delay_sat[ADDR_W-1:0];
    chain[0].wr_addr = wpos;
    chain[0].left    = count_sat;
    chain[0].echo    = sample_in;
    chain[0].sum     = sample_in;
  end

  for (genvar k = 0; k < MAX_ECHOES; k++) begin : g_cell
    mte_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .att  (att_sat),
      .prev (chain[k]),
      .nxt  (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= chain[MAX_ECHOES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      sample_out <= chain[MAX_ECHOES].sum;
    end
  end

  `ASSERT_SAME(a_ready_when_free, !out_valid, in_ready, "input blocked with empty output")
  `ASSERT_NEXT(a_wpos_step, accept, wpos == ADDR_W'($past(wpos) + ADDR_W'(1)), "write position skipped")
  `ASSERT_SAME(a_seen_bound, 1'b1, int'(seen) <= MAX_DELAY, "history count past depth")
  `ASSERT_NEXT(a_clip_restart, accept && clip_start, seen == SEEN_W'(1), "clip start not restarting history")

endmodule

`default_nettype wire

FILE: hw/rtl/mte_ram.sv
`default_nettype none

module mte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when both ports hit the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mte_cell.sv
`default_nettype none

module mte_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic [mte_pkg::ATT_W-1:0]  att,
  input  wire mte_pkg::tap_t              prev,
  output mte_pkg::tap_t                   nxt
);
  import mte_pkg::*;

  logic                       vld;
  logic                       rd_ok;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic [LEFT_W-1:0]          left;
  logic signed [SAMPLE_W-1:0] sum;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] echo;

  // delay line of this cell's input signal
  mte_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk   (clk),
    .we    (adv && prev.vld),
    .waddr (prev.wr_addr),
    .wdata (prev.echo),
    .re    (adv),
    .raddr (prev.rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_ok   <= prev.rd_ok;
      rd_addr <= prev.rd_addr;
      wr_addr <= prev.wr_addr;
      left    <= prev.left;
      sum     <= prev.sum;
    end
  end

  // history not yet written for this clip reads as silence
  assign echo = rd_ok ? attenuate($signed(rdata), att) : '0;

  always_comb begin
    nxt.vld     = vld;
    nxt.rd_ok   = rd_ok;
    nxt.rd_addr = rd_addr;
    nxt.wr_addr = wr_addr;
    nxt.echo    = echo;
    if (left != '0) begin
      nxt.sum  = sum + echo;
      nxt.left = left - LEFT_W'(1);
    end else begin
      nxt.sum  = sum;
      nxt.left = left;
    end
  end

endmodule

`default_nettype wire
